// ===== rtl/core/dcb_pkg.sv =====
// Shared types and constants for the dyadic cell binning block.
package dcb_pkg;

   // Fixed field widths of the point and result words
   localparam int COORD_W     = 17;
   localparam int NUM_COORDS  = 4;
   localparam int SLOT_W      = 8;
   localparam int CNT_W       = 16;
   localparam int DIMS_W      = 3;
   localparam int DEPTH_W     = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 5;

   // Saturation limit of the point index and the cell counts
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_DEPTH = 1'b1;

   // Configuration reset values
   localparam logic [DIMS_W-1:0]  DIMS_RESET  = 3'd4;
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic start;   // capture the accepted point and reset the search
      logic scan;    // issue the next table read and compare the last one
      logic commit;  // update the table and form the result
      logic load;    // move the result into the output register
   } dcb_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic hit;        // the entry read last cycle holds the point's code
      logic scan_done;  // every occupied slot has been compared without a hit
      logic out_free;   // the output register can take a word this cycle
   } dcb_stat_type;

endpackage

// ===== rtl/core/dcb_ctrl.sv =====
// Controller state machine sequencing capture, table search and result hand-off.
module dcb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dcb_pkg::dcb_stat_type stat,
   output dcb_pkg::dcb_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // A new point is taken only between searches
   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.scan = 1'b1;
            if (stat.hit || stat.scan_done) begin
               cmd.commit = 1'b1;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/dcb_datapath.sv =====
// Datapath: cell code generation, cell table memory, counters and output register.
module dcb_datapath #(
   parameter int DIMS       = 4,
   parameter int MAX_DEPTH  = 16,
   parameter int MAX_CELLS  = 256,
   parameter int COORD_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dcb_pkg::dcb_cmd_type                cmd,
   output dcb_pkg::dcb_stat_type               stat,
   input  logic                                csr_we,
   input  logic [dcb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dcb_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                req_first_point,
   input  logic [dcb_pkg::COORD_W-1:0]         req_coord_0,
   input  logic [dcb_pkg::COORD_W-1:0]         req_coord_1,
   input  logic [dcb_pkg::COORD_W-1:0]         req_coord_2,
   input  logic [dcb_pkg::COORD_W-1:0]         req_coord_3,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [dcb_pkg::SLOT_W-1:0]          rsp_cell_slot,
   output logic                                rsp_new_cell,
   output logic                                rsp_table_full,
   output logic [dcb_pkg::CNT_W-1:0]           rsp_point_index,
   output logic [dcb_pkg::CNT_W-1:0]           rsp_cell_count
);

   localparam int CODE_W  = DIMS * MAX_DEPTH;
   localparam int ENTRY_W = CODE_W + dcb_pkg::CNT_W;
   localparam int ADDR_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int USED_W  = $clog2(MAX_CELLS + 1);
   localparam logic [USED_W-1:0] USED_MAX = USED_W'(MAX_CELLS);

   // Configuration registers
   logic [dcb_pkg::DIMS_W-1:0]  dims_ff;
   logic [dcb_pkg::DEPTH_W-1:0] depth_ff;
   logic [dcb_pkg::DIMS_W-1:0]  dims_eff;
   logic [dcb_pkg::DEPTH_W-1:0] depth_eff;

   // Point capture and search state
   logic [CODE_W-1:0]           code_ff;
   logic [CODE_W-1:0]           code_in;
   logic [USED_W-1:0]           used_ff;
   logic [dcb_pkg::CNT_W-1:0]   pcnt_ff;
   logic [dcb_pkg::CNT_W-1:0]   idx_ff;
   logic [USED_W-1:0]           scan_ff;
   logic                        pend_ff;
   logic [ADDR_W-1:0]           rd_addr_ff;
   logic [ENTRY_W-1:0]          rdata_ff;
   logic                        issue;

   // Result held until the output register is free
   logic [dcb_pkg::SLOT_W-1:0]  res_slot_ff;
   logic                        res_new_ff;
   logic                        res_full_ff;
   logic [dcb_pkg::CNT_W-1:0]   res_count_ff;

   // Output register
   logic                        rsp_valid_ff;
   logic [dcb_pkg::SLOT_W-1:0]  rsp_slot_ff;
   logic                        rsp_new_ff;
   logic                        rsp_full_ff;
   logic [dcb_pkg::CNT_W-1:0]   rsp_index_ff;
   logic [dcb_pkg::CNT_W-1:0]   rsp_count_ff;

   // Cell table: code in the upper bits, point count in the lower bits
   logic [ENTRY_W-1:0]          table_mem [MAX_CELLS];
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [ENTRY_W-1:0]          wr_data;

   logic [dcb_pkg::COORD_W-1:0] coord_arr [dcb_pkg::NUM_COORDS];
   logic [dcb_pkg::CNT_W-1:0]   hit_count;
   logic                        room;

   // Clamp the configuration to the supported ranges
   always_comb begin
      if (dims_ff == '0) begin
         dims_eff = 3'd1;
      end else if (dims_ff > dcb_pkg::DIMS_W'(DIMS)) begin
         dims_eff = dcb_pkg::DIMS_W'(DIMS);
      end else begin
         dims_eff = dims_ff;
      end
      if (depth_ff > dcb_pkg::DEPTH_W'(MAX_DEPTH)) begin
         depth_eff = dcb_pkg::DEPTH_W'(MAX_DEPTH);
      end else begin
         depth_eff = depth_ff;
      end
   end

   assign coord_arr[0] = req_coord_0;
   assign coord_arr[1] = req_coord_1;
   assign coord_arr[2] = req_coord_2;
   assign coord_arr[3] = req_coord_3;

   // Cell code: the halving decisions of a coordinate below one are its
   // fraction bits taken from the top down; at or above one they are all ones.
   always_comb begin
      logic [15:0] frac_rev;
      logic        at_one;
      code_in = '0;
      for (int j = 0; j < DIMS; j++) begin
         at_one   = |coord_arr[j][dcb_pkg::COORD_W-1:COORD_BITS];
         frac_rev = '0;
         for (int b = 0; b < COORD_BITS; b++) begin
            frac_rev[b] = coord_arr[j][COORD_BITS-1-b];
         end
         for (int i = 0; i < MAX_DEPTH; i++) begin
            code_in[j*MAX_DEPTH+i] = (j < int'(dims_eff)) && (i < int'(depth_eff))
                                     && (at_one || frac_rev[i]);
         end
      end
   end

   // Search status: one table read is issued per cycle while slots remain
   assign issue          = cmd.scan && (scan_ff < used_ff);
   assign stat.hit       = pend_ff && (rdata_ff[ENTRY_W-1:dcb_pkg::CNT_W] == code_ff);
   assign stat.scan_done = (scan_ff >= used_ff) && !stat.hit;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign hit_count = (rdata_ff[dcb_pkg::CNT_W-1:0] == dcb_pkg::CNT_MAX)
                      ? dcb_pkg::CNT_MAX : rdata_ff[dcb_pkg::CNT_W-1:0] + 1'b1;
   assign room      = (used_ff < USED_MAX);

   // Table write on commit: bump the count of a hit or create a new cell
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_addr_ff;
      wr_data = {code_ff, hit_count};
      if (cmd.commit) begin
         if (stat.hit) begin
            wr_en = 1'b1;
         end else if (room) begin
            wr_en   = 1'b1;
            wr_addr = used_ff[ADDR_W-1:0];
            wr_data = {code_ff, dcb_pkg::CNT_W'(1)};
         end
      end
   end

   // Cell table memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= table_mem[scan_ff[ADDR_W-1:0]];
   end

   // Control registers: configuration, counters and search position
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff      <= dcb_pkg::DIMS_RESET;
         depth_ff     <= dcb_pkg::DEPTH_RESET;
         used_ff      <= '0;
         pcnt_ff      <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               dcb_pkg::CSR_DIMS_IN_USE: dims_ff  <= csr_data[dcb_pkg::DIMS_W-1:0];
               dcb_pkg::CSR_SPLIT_DEPTH: depth_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.start) begin
            scan_ff <= '0;
            pend_ff <= 1'b0;
            if (req_first_point) begin
               used_ff <= '0;
               pcnt_ff <= dcb_pkg::CNT_W'(1);
            end else if (pcnt_ff != dcb_pkg::CNT_MAX) begin
               pcnt_ff <= pcnt_ff + 1'b1;
            end
         end else begin
            pend_ff <= issue;
            if (issue) begin
               scan_ff <= scan_ff + 1'b1;
            end
            if (cmd.commit && !stat.hit && room) begin
               used_ff <= used_ff + 1'b1;
            end
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         code_ff <= code_in;
         idx_ff  <= req_first_point ? '0 : pcnt_ff;
      end
      if (issue) begin
         rd_addr_ff <= scan_ff[ADDR_W-1:0];
      end
      if (cmd.commit) begin
         if (stat.hit) begin
            res_slot_ff  <= dcb_pkg::SLOT_W'(rd_addr_ff);
            res_new_ff   <= 1'b0;
            res_full_ff  <= 1'b0;
            res_count_ff <= hit_count;
         end else if (room) begin
            res_slot_ff  <= dcb_pkg::SLOT_W'(used_ff);
            res_new_ff   <= 1'b1;
            res_full_ff  <= 1'b0;
            res_count_ff <= dcb_pkg::CNT_W'(1);
         end else begin
            res_slot_ff  <= '0;
            res_new_ff   <= 1'b0;
            res_full_ff  <= 1'b1;
            res_count_ff <= '0;
         end
      end
      if (cmd.load) begin
         rsp_slot_ff  <= res_slot_ff;
         rsp_new_ff   <= res_new_ff;
         rsp_full_ff  <= res_full_ff;
         rsp_index_ff <= idx_ff;
         rsp_count_ff <= res_count_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_slot   = rsp_slot_ff;
   assign rsp_new_cell    = rsp_new_ff;
   assign rsp_table_full  = rsp_full_ff;
   assign rsp_point_index = rsp_index_ff;
   assign rsp_cell_count  = rsp_count_ff;

endmodule

// ===== rtl/core/dyadic_cell_binning.sv =====
// Dyadic cell binning: bins each point into a table of distinct grid cells.
// Each accepted point is turned into a cell code and compared against the
// occupied slots of the cell table, one slot per cycle through the table's
// single registered read port. The search ends at the first slot that holds
// the point's code, or once every occupied slot has been compared; the point
// then counts into that cell, creates a new cell or finds the table full.
// The result word sits in an output register, so the next point is taken
// while it waits. The table needs no clearing after reset or on first_point.
module dyadic_cell_binning #(
   parameter int DIMS       = 4,
   parameter int MAX_DEPTH  = 16,
   parameter int MAX_CELLS  = 256,
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [dcb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dcb_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_first_point,
   input  logic [dcb_pkg::COORD_W-1:0]    req_coord_0,
   input  logic [dcb_pkg::COORD_W-1:0]    req_coord_1,
   input  logic [dcb_pkg::COORD_W-1:0]    req_coord_2,
   input  logic [dcb_pkg::COORD_W-1:0]    req_coord_3,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dcb_pkg::SLOT_W-1:0]     rsp_cell_slot,
   output logic                           rsp_new_cell,
   output logic                           rsp_table_full,
   output logic [dcb_pkg::CNT_W-1:0]      rsp_point_index,
   output logic [dcb_pkg::CNT_W-1:0]      rsp_cell_count
);

   dcb_pkg::dcb_cmd_type  cmd;
   dcb_pkg::dcb_stat_type stat;

   // Sequencing of each point
   dcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Code generation, cell table and result word
   dcb_datapath #(
      .DIMS       (DIMS),
      .MAX_DEPTH  (MAX_DEPTH),
      .MAX_CELLS  (MAX_CELLS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_first_point (req_first_point),
      .req_coord_0     (req_coord_0),
      .req_coord_1     (req_coord_1),
      .req_coord_2     (req_coord_2),
      .req_coord_3     (req_coord_3),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_cell_slot   (rsp_cell_slot),
      .rsp_new_cell    (rsp_new_cell),
      .rsp_table_full  (rsp_table_full),
      .rsp_point_index (rsp_point_index),
      .rsp_cell_count  (rsp_cell_count)
   );

endmodule

// ===== bench/dyadic_cell_binning_test.sv =====
// Self-checking testbench for the dyadic cell binning block.
module dyadic_cell_binning_test;

   localparam int DIMS        = 4;
   localparam int MAX_DEPTH   = 16;
   localparam int MAX_CELLS   = 256;
   localparam int COORD_BITS  = 16;
   localparam int HALF_PERIOD = 5;
   localparam int COORD_ONE   = 1 << COORD_BITS;
   localparam int COORD_HALF  = COORD_ONE / 2;
   localparam int LONG_HOLD   = 700;
   localparam int TAIL_CYCLES = 300;
   localparam int REPORT_CAP  = 200;
   localparam int unsigned CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic                                                first_point;
      logic [dcb_pkg::NUM_COORDS-1:0][dcb_pkg::COORD_W-1:0] coord;
   } point_type;

   typedef struct packed {
      logic [dcb_pkg::SLOT_W-1:0] cell_slot;
      logic                       new_cell;
      logic                       table_full;
      logic [dcb_pkg::CNT_W-1:0]  point_index;
      logic [dcb_pkg::CNT_W-1:0]  cell_count;
   } bin_result_type;

   // A directed row is a point checked by the predictor, a point with its
   // result typed in, or a register write.
   typedef enum logic [1:0] {ROW_POINT, ROW_TYPED, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      point_type                      pt;
      bin_result_type                 want;
      logic [dcb_pkg::CSR_IDX_W-1:0]  reg_index;
      logic [dcb_pkg::CSR_DATA_W-1:0] reg_value;
   } plan_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we = 1'b0;
   logic [dcb_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [dcb_pkg::CSR_DATA_W-1:0] csr_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_first_point = 1'b0;
   logic [dcb_pkg::COORD_W-1:0]    req_coord_0 = '0;
   logic [dcb_pkg::COORD_W-1:0]    req_coord_1 = '0;
   logic [dcb_pkg::COORD_W-1:0]    req_coord_2 = '0;
   logic [dcb_pkg::COORD_W-1:0]    req_coord_3 = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [dcb_pkg::SLOT_W-1:0]     rsp_cell_slot;
   logic                           rsp_new_cell;
   logic                           rsp_table_full;
   logic [dcb_pkg::CNT_W-1:0]      rsp_point_index;
   logic [dcb_pkg::CNT_W-1:0]      rsp_cell_count;

   // Predictor state: the cell table, the point counter and the registers.
   logic [63:0]                 cell_code_store [MAX_CELLS];
   logic [dcb_pkg::CNT_W-1:0]   cell_tally [MAX_CELLS];
   int                          cells_open = 0;
   logic [dcb_pkg::CNT_W-1:0]   points_seen = '0;
   logic [dcb_pkg::DIMS_W-1:0]  grid_dims = dcb_pkg::DIMS_RESET;
   logic [dcb_pkg::DEPTH_W-1:0] grid_depth = dcb_pkg::DEPTH_RESET;

   bin_result_type              expected_bins [$];
   plan_row_type                plan [$];
   logic [dcb_pkg::COORD_W-1:0] coord_pool [8];
   int                          fail_count = 0;
   int unsigned                 cycle_count = 0;
   bit                          send_idle_on = 1'b0;
   bit                          rsp_idle_on = 1'b0;
   int                          holds_asked = 0;
   int                          holds_served = 0;
   int                          hold_left = 0;
   int                          stall_left = 0;

   dyadic_cell_binning #(
      .DIMS(DIMS),
      .MAX_DEPTH(MAX_DEPTH),
      .MAX_CELLS(MAX_CELLS),
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_first_point(req_first_point),
      .req_coord_0(req_coord_0),
      .req_coord_1(req_coord_1),
      .req_coord_2(req_coord_2),
      .req_coord_3(req_coord_3),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cell_slot(rsp_cell_slot),
      .rsp_new_cell(rsp_new_cell),
      .rsp_table_full(rsp_table_full),
      .rsp_point_index(rsp_point_index),
      .rsp_cell_count(rsp_cell_count)
   );

   always #HALF_PERIOD clock = ~clock;

   // Halving decisions of one coordinate against exact dyadic midpoints.
   function automatic logic [MAX_DEPTH-1:0] halving_code(logic [dcb_pkg::COORD_W-1:0] c,
                                                         int depth);
      logic [dcb_pkg::COORD_W+MAX_DEPTH-1:0] scaled;
      logic [dcb_pkg::COORD_W+MAX_DEPTH-1:0] mid;
      logic [dcb_pkg::COORD_W+MAX_DEPTH-1:0] step;
      logic [MAX_DEPTH-1:0]                  code;
      scaled = {c, {MAX_DEPTH{1'b0}}};
      mid = '0;
      mid[COORD_BITS+MAX_DEPTH-1] = 1'b1;
      step = mid >> 1;
      code = '0;
      for (int i = 0; i < depth; i++) begin
         if (scaled < mid) begin
            mid = mid - step;
         end else begin
            code[i] = 1'b1;
            mid = mid + step;
         end
         step = step >> 1;
      end
      return code;
   endfunction

   // Bins one point into the predicted table and returns the expected word.
   function automatic bin_result_type bin_point(point_type p);
      int             dims;
      int             depth;
      int             hit_slot;
      logic [63:0]    code;
      bin_result_type r;
      dims = (grid_dims == 0) ? 1 : ((grid_dims > DIMS) ? DIMS : int'(grid_dims));
      depth = (grid_depth > MAX_DEPTH) ? MAX_DEPTH : int'(grid_depth);
      if (p.first_point) begin
         cells_open = 0;
         points_seen = '0;
      end
      code = '0;
      for (int j = 0; j < dims; j++)
         code = code | (64'(halving_code(p.coord[j], depth)) << (j * MAX_DEPTH));
      r = '0;
      r.point_index = points_seen;
      if (points_seen != dcb_pkg::CNT_MAX) points_seen = points_seen + 1'b1;
      hit_slot = -1;
      for (int s = 0; s < cells_open && hit_slot < 0; s++)
         if (cell_code_store[s] == code) hit_slot = s;
      if (hit_slot >= 0) begin
         if (cell_tally[hit_slot] != dcb_pkg::CNT_MAX)
            cell_tally[hit_slot] = cell_tally[hit_slot] + 1'b1;
         r.cell_slot = dcb_pkg::SLOT_W'(hit_slot);
         r.cell_count = cell_tally[hit_slot];
      end else if (cells_open < MAX_CELLS) begin
         cell_code_store[cells_open] = code;
         cell_tally[cells_open] = dcb_pkg::CNT_W'(1);
         r.cell_slot = dcb_pkg::SLOT_W'(cells_open);
         r.new_cell = 1'b1;
         r.cell_count = dcb_pkg::CNT_W'(1);
         cells_open++;
      end else begin
         r.table_full = 1'b1;
      end
      return r;
   endfunction

   // A coordinate: mostly from the phase's pool in cluster mode, otherwise
   // uniform over [0,1] with the edges of the range mixed in.
   function automatic logic [dcb_pkg::COORD_W-1:0] draw_coord(bit cluster);
      logic [dcb_pkg::COORD_W-1:0] v;
      if (cluster && $urandom_range(0, 3) != 0) begin
         v = coord_pool[$urandom_range(0, 7)];
      end else if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 5))
            0: v = '0;
            1: v = dcb_pkg::COORD_W'(1);
            2: v = dcb_pkg::COORD_W'(COORD_HALF - 1);
            3: v = dcb_pkg::COORD_W'(COORD_HALF);
            4: v = dcb_pkg::COORD_W'(COORD_ONE - 1);
            default: v = dcb_pkg::COORD_W'(COORD_ONE);
         endcase
      end else begin
         v = dcb_pkg::COORD_W'($urandom_range(0, COORD_ONE));
      end
      return v;
   endfunction

   function automatic plan_row_type point_row(logic first, int c0, int c1, int c2, int c3);
      plan_row_type r;
      r = '0;
      r.kind = ROW_POINT;
      r.pt.first_point = first;
      r.pt.coord[0] = dcb_pkg::COORD_W'(c0);
      r.pt.coord[1] = dcb_pkg::COORD_W'(c1);
      r.pt.coord[2] = dcb_pkg::COORD_W'(c2);
      r.pt.coord[3] = dcb_pkg::COORD_W'(c3);
      return r;
   endfunction

   function automatic plan_row_type typed_row(logic first, int c0, int c1, int c2, int c3,
                                              int slot, logic newc, logic full, int idx,
                                              int cnt);
      plan_row_type r;
      r = point_row(first, c0, c1, c2, c3);
      r.kind = ROW_TYPED;
      r.want.cell_slot = dcb_pkg::SLOT_W'(slot);
      r.want.new_cell = newc;
      r.want.table_full = full;
      r.want.point_index = dcb_pkg::CNT_W'(idx);
      r.want.cell_count = dcb_pkg::CNT_W'(cnt);
      return r;
   endfunction

   function automatic plan_row_type reg_row(logic [dcb_pkg::CSR_IDX_W-1:0] idx, int value);
      plan_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.reg_index = idx;
      r.reg_value = dcb_pkg::CSR_DATA_W'(value);
      return r;
   endfunction

   // Register write; the predictor takes the new value at once, since the
   // block is idle whenever this is called.
   task automatic write_reg(logic [dcb_pkg::CSR_IDX_W-1:0] idx,
                            logic [dcb_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_data = value;
      if (idx == dcb_pkg::CSR_DIMS_IN_USE) grid_dims = value[dcb_pkg::DIMS_W-1:0];
      else grid_depth = value[dcb_pkg::DEPTH_W-1:0];
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Offers one point and holds it until accepted, then records the result.
   task automatic send_point(point_type p, bit typed, bin_result_type typed_want);
      bin_result_type want;
      @(negedge clock);
      req_valid = 1'b1;
      req_first_point = p.first_point;
      req_coord_0 = p.coord[0];
      req_coord_1 = p.coord[1];
      req_coord_2 = p.coord[2];
      req_coord_3 = p.coord[3];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = bin_point(p);
      expected_bins.push_back(typed ? typed_want : want);
   endtask

   // Stops offering points and waits until every expected word has come.
   task automatic drain_block();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_bins.size() != 0) @(posedge clock);
   endtask

   // One random phase under one register setting.
   task automatic run_phase(int dims, int depth, int count, int first_odds,
                            bit cluster, bit idle, bit open_set);
      point_type p;
      int        gap;
      drain_block();
      write_reg(dcb_pkg::CSR_DIMS_IN_USE, dcb_pkg::CSR_DATA_W'(dims));
      write_reg(dcb_pkg::CSR_SPLIT_DEPTH, dcb_pkg::CSR_DATA_W'(depth));
      foreach (coord_pool[k]) coord_pool[k] = draw_coord(1'b0);
      send_idle_on = idle;
      rsp_idle_on = idle;
      for (int n = 0; n < count; n++) begin
         if (n == 0) p.first_point = open_set;
         else p.first_point = (first_odds != 0 && $urandom_range(1, first_odds) == 1);
         for (int j = 0; j < dcb_pkg::NUM_COORDS; j++) p.coord[j] = draw_coord(cluster);
         send_point(p, 1'b0, '0);
         if (send_idle_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 14);
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic report_field(string field, logic [dcb_pkg::CNT_W-1:0] want,
                               logic [dcb_pkg::CNT_W-1:0] got);
      fail_count++;
      if (fail_count <= REPORT_CAP)
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
   endtask

   // Result side: random stall bursts, plus one long hold-off on request.
   always @(negedge clock) begin
      if (holds_served != holds_asked) begin
         holds_served = holds_asked;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else if (rsp_idle_on && $urandom_range(0, 11) == 0) begin
         rsp_ready = 1'b0;
         stall_left = $urandom_range(0, 13);
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // Each accepted result word is compared with the oldest expectation.
   always @(posedge clock) begin
      bin_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bins.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
               $display("%0t: result word expected none, got slot %0d index %0d",
                        $time, rsp_cell_slot, rsp_point_index);
         end else begin
            want = expected_bins.pop_front();
            if (rsp_cell_slot !== want.cell_slot)
               report_field("cell_slot", dcb_pkg::CNT_W'(want.cell_slot),
                            dcb_pkg::CNT_W'(rsp_cell_slot));
            if (rsp_new_cell !== want.new_cell)
               report_field("new_cell", dcb_pkg::CNT_W'(want.new_cell),
                            dcb_pkg::CNT_W'(rsp_new_cell));
            if (rsp_table_full !== want.table_full)
               report_field("table_full", dcb_pkg::CNT_W'(want.table_full),
                            dcb_pkg::CNT_W'(rsp_table_full));
            if (rsp_point_index !== want.point_index)
               report_field("point_index", want.point_index, rsp_point_index);
            if (rsp_cell_count !== want.cell_count)
               report_field("cell_count", want.cell_count, rsp_cell_count);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      // Directed part, under the reset setting of four dimensions and full depth.
      plan.push_back(typed_row(1'b0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 0, 1));
      plan.push_back(typed_row(1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 1, 2));
      plan.push_back(typed_row(1'b0, COORD_ONE, COORD_ONE, COORD_ONE, COORD_ONE,
                               1, 1'b1, 1'b0, 2, 1));
      plan.push_back(point_row(1'b0, COORD_ONE - 1, COORD_ONE - 1, COORD_ONE - 1,
                               COORD_ONE - 1));
      plan.push_back(point_row(1'b0, COORD_HALF, COORD_HALF, COORD_HALF, COORD_HALF));
      plan.push_back(point_row(1'b0, COORD_HALF - 1, COORD_HALF - 1, COORD_HALF - 1,
                               COORD_HALF - 1));
      plan.push_back(point_row(1'b0, COORD_ONE, 0, COORD_HALF, 1));
      plan.push_back(point_row(1'b0, 'h0AAAA, 'h05555, 'h0FFFF, 'h10000));
      // A new set empties the table, also twice in a row.
      plan.push_back(typed_row(1'b1, 0, 0, 0, 0, 0, 1'b1, 1'b0, 0, 1));
      plan.push_back(typed_row(1'b1, 0, 0, 0, 0, 0, 1'b1, 1'b0, 0, 1));
      plan.push_back(typed_row(1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 1, 2));
      plan.push_back(point_row(1'b0, 1, 1, 1, 1));
      // Zero depth puts every point into a single cell.
      plan.push_back(reg_row(dcb_pkg::CSR_DIMS_IN_USE, 1));
      plan.push_back(reg_row(dcb_pkg::CSR_SPLIT_DEPTH, 0));
      plan.push_back(typed_row(1'b1, 12345, 'h0AAAA, 7, COORD_ONE, 0, 1'b1, 1'b0, 0, 1));
      plan.push_back(typed_row(1'b0, COORD_ONE, 0, 0, 0, 0, 1'b0, 1'b0, 1, 2));
      // One halving in one dimension; the unused dimensions are ignored.
      plan.push_back(reg_row(dcb_pkg::CSR_SPLIT_DEPTH, 1));
      plan.push_back(typed_row(1'b1, COORD_HALF - 1, 0, 0, 0, 0, 1'b1, 1'b0, 0, 1));
      plan.push_back(typed_row(1'b0, COORD_HALF, COORD_ONE, 0, 0, 1, 1'b1, 1'b0, 1, 1));
      plan.push_back(typed_row(1'b0, 0, 12345, 0, 0, 0, 1'b0, 1'b0, 2, 2));
      // Out-of-range settings are clamped, and a set spans the change of setting.
      plan.push_back(reg_row(dcb_pkg::CSR_DIMS_IN_USE, 0));
      plan.push_back(reg_row(dcb_pkg::CSR_SPLIT_DEPTH, 31));
      plan.push_back(point_row(1'b0, 0, COORD_ONE, 1, 2));
      plan.push_back(reg_row(dcb_pkg::CSR_DIMS_IN_USE, 7));
      plan.push_back(point_row(1'b0, 0, 0, 0, 0));
      plan.push_back(point_row(1'b0, COORD_ONE, COORD_ONE, COORD_ONE, COORD_ONE));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_CSR) begin
            drain_block();
            write_reg(plan[r].reg_index, plan[r].reg_value);
         end else begin
            send_point(plan[r].pt, plan[r].kind == ROW_TYPED, plan[r].want);
         end
      end

      // Coarse two-dimensional grid, with the result side held off at first so
      // that the block backs up onto its input.
      holds_asked++;
      run_phase(2, 3, 250, 80, 1'b0, 1'b1, 1'b1);
      // One set of distinct points well past the table size.
      run_phase(4, 16, 300, 0, 1'b0, 1'b1, 1'b1);
      run_phase(1, 16, 100, 60, 1'b1, 1'b1, 1'b0);
      run_phase(3, 5, 300, 100, 1'b1, 1'b0, 1'b1);
      // Exactly as many possible cells as table slots.
      run_phase(4, 2, 300, 0, 1'b0, 1'b1, 1'b1);
      repeat (4) begin
         run_phase($urandom_range(1, DIMS), $urandom_range(0, MAX_DEPTH), 100, 40,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end
      // Closing set with no idling on either side.
      run_phase(2, 4, 100, 30, 1'b1, 1'b0, 1'b1);

      drain_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_bins.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/dcb_pkg.sv
rtl/core/dcb_ctrl.sv
rtl/core/dcb_datapath.sv
rtl/core/dyadic_cell_binning.sv
bench/dyadic_cell_binning_test.sv
